>>> rtl/core/bra_pkg.sv
`default_nettype none

package bra_pkg;

    // Physical size of the allocation map in bytes.
    localparam int MAP_BYTES = 512;
    localparam int ADDR_W    = $clog2(MAP_BYTES);

    localparam int OP_W       = 3;
    localparam int BIT_IDX_W  = 12;
    localparam int RUN_LEN_W  = 13;
    localparam int CFG_W      = 10;
    localparam int NBYTES_W   = CFG_W;
    localparam int APB_AW     = 3;
    localparam int APB_DW     = 32;

    localparam logic [CFG_W-1:0] CFG_MAP_BYTES_RESET = 10'd512;
    localparam logic             CFG_IDX_MAP_BYTES   = 1'b0;

    localparam logic [OP_W-1:0] OP_CLEAR_ALL = 3'd0;
    localparam logic [OP_W-1:0] OP_TEST      = 3'd1;
    localparam logic [OP_W-1:0] OP_SET       = 3'd2;
    localparam logic [OP_W-1:0] OP_CLEAR     = 3'd3;
    localparam logic [OP_W-1:0] OP_SCAN      = 3'd4;

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_DISPATCH,
        S_MODIFY,
        S_SCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic clr_run;
        logic rd_byte;
        logic modify;
        logic scan_start;
        logic scan_run;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            clr_last;
        logic            scan_done;
        logic            out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

>>> rtl/core/bra_req_if.sv
`default_nettype none

interface bra_req_if import bra_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [OP_W-1:0]      operation;
    logic [BIT_IDX_W-1:0] bit_index;
    logic [RUN_LEN_W-1:0] run_length;

    modport source (output valid, output operation, output bit_index, output run_length,
                    input ready);
    modport sink   (input valid, input operation, input bit_index, input run_length,
                    output ready);
endinterface

`default_nettype wire

>>> rtl/core/bra_rsp_if.sv
`default_nettype none

interface bra_rsp_if import bra_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 bit_value;
    logic                 found;
    logic [BIT_IDX_W-1:0] run_start;

    modport source (output valid, output bit_value, output found, output run_start,
                    input ready);
    modport sink   (input valid, input bit_value, input found, input run_start,
                    output ready);
endinterface

`default_nettype wire

>>> rtl/core/bra_ram.sv
`default_nettype none

module bra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/bra_ctrl.sv
`default_nettype none

module bra_ctrl import bra_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    t_state r_state, n_state;
    logic   r_reply, n_reply;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_reply <= 1'b0;
        end else begin
            r_state <= n_state;
            r_reply <= n_reply;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_reply    = r_reply;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_CLR: begin
                o_cmd.clr_run = 1'b1;
                if (i_stat.clr_last) begin
                    // The sweep after reset has no beat to answer.
                    n_state = r_reply ? S_DONE : S_IDLE;
                    n_reply = 1'b0;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (i_stat.op)
                    OP_CLEAR_ALL: begin
                        n_state = S_CLR;
                        n_reply = 1'b1;
                    end
                    OP_TEST, OP_SET, OP_CLEAR: begin
                        o_cmd.rd_byte = 1'b1;
                        n_state       = S_MODIFY;
                    end
                    OP_SCAN: begin
                        o_cmd.scan_start = 1'b1;
                        n_state          = S_SCAN;
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_MODIFY: begin
                o_cmd.modify = 1'b1;
                n_state      = S_DONE;
            end
            S_SCAN: begin
                o_cmd.scan_run = 1'b1;
                if (i_stat.scan_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/core/bra_datapath.sv
`default_nettype none

module bra_datapath import bra_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_dp_cmd              i_cmd,
    output t_dp_stat                  o_stat,
    input  wire logic [NBYTES_W-1:0]  i_nbytes,
    input  wire logic [OP_W-1:0]      i_operation,
    input  wire logic [BIT_IDX_W-1:0] i_bit_index,
    input  wire logic [RUN_LEN_W-1:0] i_run_length,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic                      o_bit_value,
    output logic                      o_found,
    output logic [BIT_IDX_W-1:0]      o_run_start
);

    localparam int BYTE_IDX_W = BIT_IDX_W - 3;

    logic [OP_W-1:0]      r_op;
    logic [BIT_IDX_W-1:0] r_idx;
    logic [RUN_LEN_W-1:0] r_want;
    logic                 r_bit_value;
    logic                 r_found;
    logic [BIT_IDX_W-1:0] r_end;
    logic [ADDR_W-1:0]    r_clr_addr;
    logic [NBYTES_W-1:0]  r_issue;
    logic                 r_pv;
    logic [ADDR_W-1:0]    r_pbyte;
    logic [RUN_LEN_W-1:0] r_count;
    logic                 r_out_valid;
    logic                 r_out_bit;
    logic                 r_out_found;
    logic [BIT_IDX_W-1:0] r_out_start;

    logic [BYTE_IDX_W-1:0] w_byte;
    logic                  w_in_store;
    logic [7:0]            w_mask;
    logic [7:0]            w_rdata;
    logic                  w_issue_ok;
    logic                  w_clr_last;
    logic                  w_we;
    logic [ADDR_W-1:0]     w_waddr;
    logic [7:0]            w_wdata;
    logic                  w_re;
    logic [ADDR_W-1:0]     w_raddr;
    logic [RUN_LEN_W-1:0]  w_count;
    logic                  w_hit;
    logic [2:0]            w_pos;
    logic [RUN_LEN_W-1:0]  w_start;

    assign w_byte     = r_idx[BIT_IDX_W-1:3];
    assign w_in_store = 32'(w_byte) < MAP_BYTES;
    assign w_mask     = 8'd1 << r_idx[2:0];
    assign w_issue_ok = r_issue < i_nbytes;
    assign w_clr_last = r_clr_addr == ADDR_W'(MAP_BYTES - 1);

    always_comb begin
        w_we    = 1'b0;
        w_waddr = w_byte[ADDR_W-1:0];
        w_wdata = w_rdata & ~w_mask;
        if (i_cmd.clr_run) begin
            w_we    = 1'b1;
            w_waddr = r_clr_addr;
            w_wdata = '0;
        end else if (i_cmd.modify && w_in_store && (r_op == OP_SET || r_op == OP_CLEAR)) begin
            w_we    = 1'b1;
            w_wdata = (r_op == OP_SET) ? (w_rdata | w_mask) : (w_rdata & ~w_mask);
        end
    end

    assign w_re    = i_cmd.rd_byte | (i_cmd.scan_run & w_issue_ok);
    assign w_raddr = i_cmd.rd_byte ? w_byte[ADDR_W-1:0] : r_issue[ADDR_W-1:0];

    bra_ram #(
        .WIDTH (8),
        .DEPTH (MAP_BYTES)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Free-bit streak over one byte, lowest bit first. The first bit at which the
    // streak reaches the wanted length ends the run. Each bit's streak is either the
    // carried count plus its offset, while the byte is free up to it, or the short
    // streak inside the byte, so no wide adder feeds another.
    always_comb begin
        logic [3:0]           tail;
        logic                 all_free;
        logic [RUN_LEN_W-1:0] streak;
        tail     = '0;
        all_free = 1'b1;
        streak   = r_count;
        w_hit    = 1'b0;
        w_pos    = '0;
        for (int j = 0; j < 8; j++) begin
            tail     = w_rdata[j] ? 4'd0 : tail + 4'd1;
            all_free = all_free & ~w_rdata[j];
            streak   = all_free ? r_count + RUN_LEN_W'(j + 1) : RUN_LEN_W'(tail);
            if (!w_hit && streak == r_want) begin
                w_hit = 1'b1;
                w_pos = 3'(j);
            end
        end
        w_count = streak;
    end

    assign w_start = RUN_LEN_W'(r_end) + 1'b1 - r_want;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op        <= i_operation;
            r_idx       <= i_bit_index;
            r_want      <= (i_run_length == '0) ? RUN_LEN_W'(1) : i_run_length;
            r_bit_value <= 1'b0;
            r_found     <= 1'b0;
            r_end       <= '0;
        end
        if (i_cmd.modify && r_op == OP_TEST) begin
            r_bit_value <= w_in_store & w_rdata[r_idx[2:0]];
        end
        if (i_cmd.scan_start) begin
            r_issue <= '0;
            r_count <= '0;
        end
        if (i_cmd.scan_run) begin
            if (w_issue_ok) begin
                r_issue <= r_issue + 1'b1;
                r_pbyte <= r_issue[ADDR_W-1:0];
            end
            if (r_pv) begin
                r_count <= w_count;
                if (w_hit) begin
                    r_found <= 1'b1;
                    r_end   <= BIT_IDX_W'({r_pbyte, w_pos});
                end
            end
        end
        if (i_cmd.out_load) begin
            r_out_bit   <= r_bit_value;
            r_out_found <= r_found;
            r_out_start <= r_found ? w_start[BIT_IDX_W-1:0] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr  <= '0;
            r_pv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_run) begin
                r_clr_addr <= w_clr_last ? '0 : r_clr_addr + 1'b1;
            end
            if (i_cmd.scan_start) begin
                r_pv <= 1'b0;
            end else if (i_cmd.scan_run) begin
                r_pv <= w_issue_ok;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_stat.op        = r_op;
        o_stat.clr_last  = w_clr_last;
        o_stat.scan_done = r_pv && (w_hit || ({1'b0, r_pbyte} == i_nbytes - 1'b1));
        o_stat.out_free  = !r_out_valid || i_ready;
    end

    assign o_valid     = r_out_valid;
    assign o_bit_value = r_out_bit;
    assign o_found     = r_out_found;
    assign o_run_start = r_out_start;

endmodule

`default_nettype wire

>>> rtl/core/bitmap_run_allocator.sv
// Channel   Dir  Handshake        Beat contents
// i_req     in   valid / ready    operation, bit_index, run_length
// o_rsp     out  valid / ready    bit_value, found, run_start
// APB       in   psel/penable     map_bytes_in_use at address 0
//
// Test, set and clear read one map byte through the single map RAM, and set and clear
// write it back. A scan streams one map byte per cycle through the run counter
// until it finds the run or reaches the configured map end. Clear all sweeps the
// whole RAM one byte a cycle. After reset the same sweep runs with i_req not ready.
// A result waits in the output register while the next beat is accepted.
`default_nettype none

module bitmap_run_allocator import bra_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    bra_req_if.sink                i_req,
    bra_rsp_if.source              o_rsp,
    input  wire logic              i_psel,
    input  wire logic              i_penable,
    input  wire logic              i_pwrite,
    input  wire logic [APB_AW-1:0] i_paddr,
    input  wire logic [APB_DW-1:0] i_pwdata,
    output logic      [APB_DW-1:0] o_prdata,
    output logic                   o_pready
);

    logic [CFG_W-1:0]    r_cfg;
    logic [NBYTES_W-1:0] w_nbytes;
    logic                w_in_ready;
    t_dp_cmd             w_cmd;
    t_dp_stat            w_stat;

    assign o_pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_MAP_BYTES_RESET;
        end else if (i_psel && i_penable && i_pwrite && i_paddr[2] == CFG_IDX_MAP_BYTES) begin
            r_cfg <= i_pwdata[CFG_W-1:0];
        end
    end

    assign o_prdata = (i_paddr[2] == CFG_IDX_MAP_BYTES) ? APB_DW'(r_cfg) : '0;

    always_comb begin
        if (r_cfg == '0) begin
            w_nbytes = NBYTES_W'(1);
        end else if (r_cfg > NBYTES_W'(MAP_BYTES)) begin
            w_nbytes = NBYTES_W'(MAP_BYTES);
        end else begin
            w_nbytes = r_cfg;
        end
    end

    bra_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (w_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    assign i_req.ready = w_in_ready;

    bra_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_nbytes     (w_nbytes),
        .i_operation  (i_req.operation),
        .i_bit_index  (i_req.bit_index),
        .i_run_length (i_req.run_length),
        .o_valid      (o_rsp.valid),
        .i_ready      (o_rsp.ready),
        .o_bit_value  (o_rsp.bit_value),
        .o_found      (o_rsp.found),
        .o_run_start  (o_rsp.run_start)
    );

    // The clearing sweep holds off input right after reset.
    a_no_accept_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !i_req.ready)
        else $error("input accepted before the map was cleared");

    a_test_and_scan_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> !(o_rsp.found && o_rsp.bit_value))
        else $error("result carries both a bit value and a found run");

    a_not_found_start_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.found) |-> (o_rsp.run_start == '0))
        else $error("run start set without a found run");

    a_run_inside_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.found) |->
            ({1'b0, o_rsp.run_start} < {w_nbytes, 3'b000}))
        else $error("found run starts beyond the configured map end");

endmodule

`default_nettype wire

>>> dv/bra_alloc_checker.sv
`timescale 1ns / 100ps

module bra_alloc_checker import bra_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    bra_req_if                req_mon,
    bra_rsp_if                rsp_mon,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic              i_pready,
    input  logic [APB_AW-1:0] i_paddr,
    input  logic [APB_DW-1:0] i_pwdata,
    output int                o_fail_count,
    output int                o_pending
);

    localparam logic [APB_AW-1:0] MAP_BYTES_ADDR = {CFG_IDX_MAP_BYTES, 2'b00};

    typedef struct packed {
        logic                 bit_value;
        logic                 found;
        logic [BIT_IDX_W-1:0] run_start;
    } t_outcome;

    logic [7:0]       alloc_map [MAP_BYTES];
    logic [CFG_W-1:0] map_bytes_cfg;
    t_outcome         pending_outcomes [$];

    // Out-of-range sizes fold onto the nearest legal one.
    function automatic int unsigned bytes_scanned();
        if (map_bytes_cfg == '0) begin
            return 1;
        end
        if (map_bytes_cfg > MAP_BYTES) begin
            return MAP_BYTES;
        end
        return map_bytes_cfg;
    endfunction

    function automatic logic map_bit(input int unsigned b);
        int unsigned byte_num;
        byte_num = b >> 3;
        if (byte_num >= MAP_BYTES) begin
            return 1'b0;
        end
        return alloc_map[byte_num][b & 7];
    endfunction

    // First fit: locate the lowest free bit, then the first window of free bits
    // counted from there that still ends inside the configured map.
    function automatic logic find_free_run(input logic [RUN_LEN_W-1:0] want_in,
                                           output logic [BIT_IDX_W-1:0] run_at);
        int unsigned nbytes;
        int unsigned total;
        int unsigned want;
        int unsigned byte_num;
        int unsigned first;
        int unsigned count;
        int unsigned b;
        run_at   = '0;
        nbytes   = bytes_scanned();
        total    = nbytes * 8;
        want     = (want_in == '0) ? 1 : want_in;
        byte_num = 0;
        while (byte_num < nbytes && alloc_map[byte_num] == 8'hff) begin
            byte_num++;
        end
        if (byte_num == nbytes) begin
            return 1'b0;
        end
        first = byte_num * 8;
        while (map_bit(first)) begin
            first++;
        end
        if (want == 1) begin
            run_at = BIT_IDX_W'(first);
            return 1'b1;
        end
        count = 1;
        for (b = first + 1; b < total; b++) begin
            count = map_bit(b) ? 0 : count + 1;
            if (count == want) begin
                run_at = BIT_IDX_W'(b - want + 1);
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic t_outcome apply_map_op(input logic [OP_W-1:0]      op,
                                              input logic [BIT_IDX_W-1:0] idx,
                                              input logic [RUN_LEN_W-1:0] len);
        t_outcome             res;
        int unsigned          byte_num;
        logic [BIT_IDX_W-1:0] run_at;
        res      = '0;
        byte_num = idx >> 3;
        case (op)
            OP_CLEAR_ALL: begin
                foreach (alloc_map[i]) begin
                    alloc_map[i] = '0;
                end
            end
            OP_TEST: begin
                res.bit_value = map_bit(idx);
            end
            OP_SET: begin
                if (byte_num < MAP_BYTES) begin
                    alloc_map[byte_num][idx[2:0]] = 1'b1;
                end
            end
            OP_CLEAR: begin
                if (byte_num < MAP_BYTES) begin
                    alloc_map[byte_num][idx[2:0]] = 1'b0;
                end
            end
            OP_SCAN: begin
                res.found     = find_free_run(len, run_at);
                res.run_start = res.found ? run_at : '0;
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_outcome want;
        if (!i_rst_n) begin
            foreach (alloc_map[i]) begin
                alloc_map[i] = '0;
            end
            map_bytes_cfg = CFG_MAP_BYTES_RESET;
            pending_outcomes.delete();
            o_fail_count = 0;
        end else begin
            // A result beat always belongs to an older request, so it is retired first.
            if (rsp_mon.valid && rsp_mon.ready) begin
                if (pending_outcomes.size() == 0) begin
                    $error("result beat with no request outstanding");
                    o_fail_count++;
                end else begin
                    want = pending_outcomes.pop_front();
                    if (rsp_mon.bit_value !== want.bit_value) begin
                        $error("bit_value: expected %0d, actual %0d",
                               want.bit_value, rsp_mon.bit_value);
                        o_fail_count++;
                    end
                    if (rsp_mon.found !== want.found) begin
                        $error("found: expected %0d, actual %0d", want.found, rsp_mon.found);
                        o_fail_count++;
                    end
                    if (rsp_mon.run_start !== want.run_start) begin
                        $error("run_start: expected %0d, actual %0d",
                               want.run_start, rsp_mon.run_start);
                        o_fail_count++;
                    end
                end
            end
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == MAP_BYTES_ADDR) begin
                map_bytes_cfg = i_pwdata[CFG_W-1:0];
            end
            if (req_mon.valid && req_mon.ready) begin
                pending_outcomes.push_back(apply_map_op(req_mon.operation, req_mon.bit_index,
                                                        req_mon.run_length));
            end
        end
        o_pending = pending_outcomes.size();
    end

endmodule

>>> dv/tb_bitmap_run_allocator.sv
`timescale 1ns / 100ps

module tb_bitmap_run_allocator;
    import bra_pkg::*;

    localparam logic [APB_AW-1:0] MAP_BYTES_ADDR  = {CFG_IDX_MAP_BYTES, 2'b00};
    localparam logic [OP_W-1:0]   OP_RSVD_LO      = 3'd5;
    localparam logic [OP_W-1:0]   OP_RSVD_HI      = 3'd7;
    localparam int                ITEMS_PER_SEG   = 100;
    localparam int                SEGMENTS        = 8;
    // The slowest operation walks the whole map once; allow that many times over.
    localparam int                WATCHDOG_LIMIT  = 8 * MAP_BYTES;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    int          fail_count;
    int          pending;
    int          send_idle_pct = 0;
    int          rsp_stall_pct = 0;
    int unsigned active_bits   = MAP_BYTES * 8;
    int          idle_cycles   = 0;

    bra_req_if req_if ();
    bra_rsp_if rsp_if ();

    bitmap_run_allocator dut (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_req     (req_if),
        .o_rsp     (rsp_if),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready)
    );

    bra_alloc_checker alloc_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .req_mon      (req_if),
        .rsp_mon      (rsp_if),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk) begin
        if (!rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            rsp_if.ready = (rsp_stall_pct == 0) || ($urandom_range(99) >= rsp_stall_pct);
        end
    end

    // Called at a falling edge; returns at the falling edge after the beat is taken,
    // with valid still high so back-to-back beats need no gap.
    task automatic send_req(input logic [OP_W-1:0]      op,
                            input logic [BIT_IDX_W-1:0] idx,
                            input logic [RUN_LEN_W-1:0] len);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            req_if.valid = 1'b0;
            @(negedge clk);
        end
        req_if.valid      = 1'b1;
        req_if.operation  = op;
        req_if.bit_index  = idx;
        req_if.run_length = len;
        do begin
            @(posedge clk);
        end while (!req_if.ready);
        @(negedge clk);
    endtask

    task automatic drain();
        req_if.valid = 1'b0;
        while (pending != 0) begin
            @(negedge clk);
        end
    endtask

    task automatic write_map_bytes(input logic [CFG_W-1:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = MAP_BYTES_ADDR;
        pwdata  = APB_DW'(value);
        @(negedge clk);
        penable = 1'b1;
        do begin
            @(posedge clk);
        end while (!pready);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        if (value == '0) begin
            active_bits = 8;
        end else if (value > MAP_BYTES) begin
            active_bits = MAP_BYTES * 8;
        end else begin
            active_bits = value * 8;
        end
    endtask

    // Most traffic lands in a small window near the map base so that sets and
    // clears fragment it and scans have to skip used stretches.
    task automatic send_random_req();
        int unsigned          pick;
        int unsigned          hot;
        logic [OP_W-1:0]      op;
        logic [BIT_IDX_W-1:0] idx;
        logic [RUN_LEN_W-1:0] len;
        hot  = (active_bits < 128) ? active_bits : 128;
        pick = $urandom_range(99);
        if (pick < 2) begin
            op = OP_CLEAR_ALL;
        end else if (pick < 37) begin
            op = OP_SET;
        end else if (pick < 57) begin
            op = OP_CLEAR;
        end else if (pick < 72) begin
            op = OP_TEST;
        end else if (pick < 97) begin
            op = OP_SCAN;
        end else begin
            op = OP_W'($urandom_range(OP_RSVD_LO, OP_RSVD_HI));
        end
        pick = $urandom_range(99);
        if (pick < 60) begin
            idx = BIT_IDX_W'($urandom_range(hot - 1));
        end else if (pick < 85) begin
            idx = BIT_IDX_W'($urandom_range(active_bits - 1));
        end else begin
            idx = BIT_IDX_W'($urandom);
        end
        pick = $urandom_range(99);
        if (pick < 50) begin
            len = RUN_LEN_W'($urandom_range(1, 8));
        end else if (pick < 75) begin
            len = RUN_LEN_W'($urandom_range(1, 32));
        end else if (pick < 90) begin
            len = RUN_LEN_W'($urandom_range(active_bits + 8));
        end else begin
            len = RUN_LEN_W'($urandom);
        end
        send_req(op, idx, len);
    endtask

    initial begin
        int          seg;
        int          n;
        logic [CFG_W-1:0] cfg_value;
        rst_n             = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        req_if.valid      = 1'b0;
        req_if.operation  = OP_CLEAR_ALL;
        req_if.bit_index  = '0;
        req_if.run_length = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Full-size map: empty-map scans, the longest runs and reserved codes.
        send_req(OP_TEST, '0, 13'd1);
        send_req(OP_SCAN, '0, 13'd1);
        send_req(OP_SCAN, '0, 13'd4096);
        send_req(OP_SCAN, '0, '0);
        send_req(OP_SCAN, '0, '1);
        send_req(OP_SET, '0, '0);
        send_req(OP_SET, '1, '0);
        send_req(OP_TEST, '1, '0);
        send_req(OP_SCAN, '0, 13'd4094);
        send_req(OP_CLEAR, '0, '1);
        send_req(OP_RSVD_LO, '1, '1);
        send_req(OP_RSVD_HI, '1, '1);
        send_req(OP_CLEAR_ALL, '1, '1);
        drain();

        // One-byte map: fill it, then free a single bit inside it.
        write_map_bytes(10'd1);
        for (n = 0; n < 8; n++) begin
            send_req(OP_SET, BIT_IDX_W'(n), '0);
        end
        send_req(OP_SCAN, '0, 13'd1);
        send_req(OP_CLEAR, 12'd5, '0);
        send_req(OP_SCAN, '0, 13'd1);
        send_req(OP_SCAN, '0, 13'd2);
        send_req(OP_TEST, '1, '0);
        drain();

        for (seg = 0; seg < SEGMENTS; seg++) begin
            case (seg / 2)
                0: begin
                    send_idle_pct = 0;
                    rsp_stall_pct = 0;
                end
                1: begin
                    send_idle_pct = 48;
                    rsp_stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    rsp_stall_pct = 48;
                end
                default: begin
                    send_idle_pct = 30;
                    rsp_stall_pct = 30;
                end
            endcase
            case (seg)
                0: cfg_value = CFG_W'(MAP_BYTES);
                1: cfg_value = 10'd1;
                2: cfg_value = '0;
                3: cfg_value = '1;
                4: cfg_value = CFG_W'($urandom_range(2, 40));
                5: cfg_value = 10'd3;
                6: cfg_value = 10'd300;
                default: cfg_value = CFG_W'($urandom_range(1, MAP_BYTES));
            endcase
            drain();
            write_map_bytes(cfg_value);
            for (n = 0; n < ITEMS_PER_SEG; n++) begin
                send_random_req();
            end
        end

        drain();
        // Room for a stray result from the longest operation.
        repeat (MAP_BYTES + 8) @(negedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/core/bra_pkg.sv
rtl/core/bra_req_if.sv
rtl/core/bra_rsp_if.sv
rtl/core/bra_ram.sv
rtl/core/bra_ctrl.sv
rtl/core/bra_datapath.sv
rtl/core/bitmap_run_allocator.sv
dv/bra_alloc_checker.sv
dv/tb_bitmap_run_allocator.sv
